>>> rtl/polygon_outline_grid_marker_core_defines.svh
// ----------------------------------------------------------------------------
// Polygon outline grid marker: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYGON_OUTLINE_GRID_MARKER_CORE_DEFINES_SVH
`define POLYGON_OUTLINE_GRID_MARKER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define POGM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define POGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pogm_pkg.sv
// ----------------------------------------------------------------------------
// Polygon outline grid marker package
// Widths, codes, payload structs and divider link types shared by the design.
// ----------------------------------------------------------------------------
package pogm_pkg;

	localparam int CoordW   = 32;
	localparam int CellW    = 21;
	localparam int DimW     = 9;
	localparam int MarkW    = 8;
	localparam int IdxW     = 16;
	localparam int CountW   = 17;
	localparam int CellCount = 65536;
	localparam int StepMax  = 65535;
	localparam int RootW    = 33;
	localparam int DvdW     = 37;
	localparam int DvsW     = 25;
	localparam int CwW      = 30;

	localparam logic [DimW-1:0] DimMax = DimW'(256);

	typedef enum logic [1:0] {
		OP_VERTEX    = 2'd0,
		OP_READ_CELL = 2'd1,
		OP_READ_LIST = 2'd2,
		OP_NONE      = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_ORIGIN_X     = 3'd0,
		CFG_ORIGIN_Y     = 3'd1,
		CFG_CELL_SIZE    = 3'd2,
		CFG_GRID_WIDTH   = 3'd3,
		CFG_GRID_HEIGHT  = 3'd4,
		CFG_PADDING_ON   = 3'd5,
		CFG_PADDING_SIZE = 3'd6,
		CFG_MARK_VALUE   = 3'd7
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_VSTART,
		ST_E_SETUP,
		ST_E_SQU,
		ST_E_SQV,
		ST_E_SUM,
		ST_E_ROOT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_P_POS,
		ST_P_CHK,
		ST_P_DIV,
		ST_P_IDX,
		ST_P_RD,
		ST_P_UPD,
		ST_P_NEXT,
		ST_E_END,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		DIV_N,
		DIV_QX,
		DIV_QY
	} div_sel_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic signed [CoordW-1:0] vertex_x;
		logic signed [CoordW-1:0] vertex_y;
		logic                     last_vertex;
		logic [IdxW-1:0]          read_index;
	} item_t;

	typedef struct packed {
		logic [MarkW-1:0]  cell_value;
		logic [IdxW-1:0]   occupied_index;
		logic [CountW-1:0] occupied_count;
		logic              polygon_done;
		logic              read_out_of_range;
	} result_t;

	typedef struct packed {
		logic            start;
		logic [DvdW-1:0] dividend;
		logic [DvsW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DvdW-1:0] quotient;
		logic [DvsW-1:0] remainder;
	} div_rsp_t;

endpackage

>>> rtl/polygon_outline_grid_marker_core.sv
// ----------------------------------------------------------------------------
// Polygon outline grid marker core
// Marks every grid cell that a closed polygon outline passes over and keeps
// a list of the cells marked in the current polygon.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  item      in         item_valid / item_ready      item_t
//  result    out        result_valid / result_ready  result_t
//  cfg       in         cfg_we                       cfg_index, cfg_data
//
//  After reset, and on the first vertex of each polygon, a clearing pass
//  writes all 65536 cell entries, one per cycle, while no request is taken.
//  A read passes the read and result states. Per edge, a vertex runs setup,
//  squares, root, a step count division and, if that count is nonzero, two
//  per axis divisions, then per edge point a cell read-modify-write that is
//  skipped off the grid. One request is in flight at a time; a finished
//  result waits in the output register while the next is taken.
// ----------------------------------------------------------------------------
module polygon_outline_grid_marker_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                item_valid,
	output logic                item_ready,
	input  pogm_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output pogm_pkg::result_t   result
);
	import pogm_pkg::*;

	// Saturating outward push of one coordinate.
	function automatic logic signed [CoordW-1:0] pad_coord(
		input logic signed [CoordW-1:0] v,
		input logic                     on,
		input logic [CellW-1:0]         ps
	);
		logic signed [CoordW+1:0] wide;
		logic signed [CoordW+1:0] amt;
		amt  = $signed({1'b0, (CoordW+1-CellW)'(0), ps});
		wide = (CoordW+2)'(v);
		if (on && v > 0) begin
			wide = wide + amt;
		end else if (on && v < 0) begin
			wide = wide - amt;
		end
		if (wide[CoordW+1] != wide[CoordW-1] || wide[CoordW] != wide[CoordW-1]) begin
			return wide[CoordW+1] ? {1'b1, (CoordW-1)'(0)} : {1'b0, {(CoordW-1){1'b1}}};
		end
		return wide[CoordW-1:0];
	endfunction

	// Configuration registers.
	logic signed [CoordW-1:0] origin_x_q, origin_y_q;
	logic [CellW-1:0]         cell_size_q, padding_size_q;
	logic [DimW-1:0]          grid_width_q, grid_height_q;
	logic                     padding_on_q;
	logic [MarkW-1:0]         mark_value_q;

	// Control state.
	state_t            state_q, state_d;
	logic [IdxW-1:0]   clr_q;
	logic              clr_vtx_q;
	logic              open_q, done_q;
	logic [CountW-1:0] len_q;
	result_t           result_q;
	logic              result_valid_q;

	// Request and vertex state.
	opcode_t                  op_q;
	logic signed [CoordW-1:0] vx_q, vy_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                     last_q, wasopen_q, roor_q, closing_q;
	logic [MarkW-1:0]         rcell_q;
	logic [IdxW-1:0]          rlist_q;

	// Edge datapath.
	logic signed [CoordW-1:0] ex0_q, ey0_q, ex1_q, ey1_q;
	logic                     negx_q, negy_q;
	logic [CoordW-1:0]        ux_q, uy_q;
	logic [CwW-1:0]           cw_q, ch_q;
	logic [2*CoordW-1:0]      prod_q, sqa_q;
	logic [2*CoordW+1:0]      rad_q;
	logic [RootW-1:0]         root_q;
	logic [RootW+1:0]         rrem_q;
	logic [5:0]               rt_cnt_q;
	div_sel_t                 div_sel_q;
	logic [IdxW-1:0]          n_q, rx_q, ry_q, accrx_q, accry_q, j_q;
	logic [CoordW-1:0]        qx_q, qy_q, accqx_q, accqy_q;

	// Point datapath.
	logic signed [CoordW+1:0] px_q, py_q;
	logic [CwW-1:0]           remx_q, remy_q;
	logic [2:0]               k_q;
	logic [7:0]               mx_q, my_q;
	logic [IdxW-1:0]          idx_q;

	// Memories.
	logic [MarkW:0]   cell_mem [CellCount];
	logic [IdxW-1:0]  list_mem [CellCount];
	logic [MarkW:0]   cell_rd_q;
	logic [IdxW-1:0]  list_rd_q;
	logic             cell_we, list_we;
	logic [IdxW-1:0]  cell_wa, cell_ra;
	logic [MarkW:0]   cell_wd;

	// Combinational helpers.
	logic [CellW-1:0]         csz;
	logic [DimW-1:0]          gw, gh;
	logic [CountW-1:0]        cells_used;
	logic                     accept, res_load;
	logic signed [CoordW-1:0] pad_x, pad_y;
	logic signed [CoordW:0]   dx, dy;
	logic [CoordW-1:0]        mul_op;
	logic [2*CoordW-1:0]      mul_res;
	logic [RootW+3:0]         rt_sh, rt_trial;
	logic [IdxW-1:0]          n_sat;
	logic signed [CoordW+2:0] offx, offy;
	logic                     inx, iny;
	logic [CwW-1:0]           dsh;
	logic [IdxW:0]            sumrx, sumry;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	pogm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Effective geometry: zero cell size acts as one, dimensions cap at 256.
	assign csz        = (cell_size_q == '0) ? CellW'(1) : cell_size_q;
	assign gw         = (grid_width_q > DimMax) ? DimMax : grid_width_q;
	assign gh         = (grid_height_q > DimMax) ? DimMax : grid_height_q;
	assign cells_used = CountW'(gw) * CountW'(gh);
	assign accept     = item_valid && item_ready;
	assign pad_x      = pad_coord(item.vertex_x, padding_on_q, padding_size_q);
	assign pad_y      = pad_coord(item.vertex_y, padding_on_q, padding_size_q);

	// Edge deltas, shared squarer and one square root step.
	assign dx       = (CoordW+1)'(ex1_q) - (CoordW+1)'(ex0_q);
	assign dy       = (CoordW+1)'(ey1_q) - (CoordW+1)'(ey0_q);
	assign mul_op   = (state_q == ST_E_SQU) ? ux_q : uy_q;
	assign mul_res  = {(CoordW)'(0), mul_op} * {(CoordW)'(0), mul_op};
	assign rt_sh    = {rrem_q, rad_q[2*CoordW+1:2*CoordW]};
	assign rt_trial = {2'b00, root_q, 2'b01};
	assign n_sat    = (div_rsp.quotient > DvdW'(StepMax)) ? IdxW'(StepMax)
	                                                      : div_rsp.quotient[IdxW-1:0];

	// Point offsets from the origin and grid bound checks.
	assign offx = (CoordW+3)'(px_q) - (CoordW+3)'(origin_x_q);
	assign offy = (CoordW+3)'(py_q) - (CoordW+3)'(origin_y_q);
	assign inx  = !offx[CoordW+2] && (offx[CoordW+1:0] < (CoordW+2)'(cw_q));
	assign iny  = !offy[CoordW+2] && (offy[CoordW+1:0] < (CoordW+2)'(ch_q));
	assign dsh  = CwW'(csz) << k_q;

	// Remainder accumulation of the edge stepping.
	assign sumrx = (IdxW+1)'(accrx_q) + (IdxW+1)'(rx_q);
	assign sumry = (IdxW+1)'(accry_q) + (IdxW+1)'(ry_q);

	// Next state and strobes.
	always_comb begin
		state_d        = state_q;
		item_ready     = 1'b0;
		res_load       = 1'b0;
		cell_we        = 1'b0;
		cell_wa        = idx_q;
		cell_wd        = {1'b1, mark_value_q};
		list_we        = 1'b0;
		cell_ra        = (state_q == ST_IDLE) ? item.read_index : idx_q;
		div_req        = '0;
		div_req.divisor  = DvsW'(n_q);
		div_req.dividend = DvdW'(ux_q);
		unique case (state_q)
			ST_CLEAR: begin
				cell_we = 1'b1;
				cell_wa = clr_q;
				cell_wd = '0;
				if (clr_q == IdxW'(CellCount - 1)) begin
					state_d = clr_vtx_q ? ST_VSTART : ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (item.opcode)
						OP_VERTEX:    state_d = open_q ? ST_VSTART : ST_CLEAR;
						OP_READ_CELL: state_d = ST_READ;
						OP_READ_LIST: state_d = ST_READ;
						OP_NONE:      state_d = ST_RESULT;
					endcase
				end
			end
			ST_READ:    state_d = ST_RESULT;
			ST_VSTART:  state_d = (wasopen_q || last_q) ? ST_E_SETUP : ST_RESULT;
			ST_E_SETUP: state_d = ST_E_SQU;
			ST_E_SQU:   state_d = ST_E_SQV;
			ST_E_SQV:   state_d = ST_E_SUM;
			ST_E_SUM:   state_d = ST_E_ROOT;
			ST_E_ROOT: begin
				if (rt_cnt_q == '0) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				div_req.start = 1'b1;
				unique case (div_sel_q)
					DIV_N: begin
						div_req.dividend = DvdW'({root_q, 3'b000}) + DvdW'({root_q, 1'b0});
						div_req.divisor  = DvsW'({csz, 3'b000}) + DvsW'(csz);
					end
					DIV_QX: begin
						div_req.dividend = DvdW'(ux_q);
					end
					DIV_QY: begin
						div_req.dividend = DvdW'(uy_q);
					end
					default: begin
						div_req.dividend = DvdW'(ux_q);
					end
				endcase
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					unique case (div_sel_q)
						DIV_N:   state_d = (n_sat == '0) ? ST_E_END : ST_DIV_GO;
						DIV_QX:  state_d = ST_DIV_GO;
						DIV_QY:  state_d = ST_P_POS;
						default: state_d = ST_E_END;
					endcase
				end
			end
			ST_P_POS:   state_d = ST_P_CHK;
			ST_P_CHK:   state_d = (inx && iny) ? ST_P_DIV : ST_P_NEXT;
			ST_P_DIV: begin
				if (k_q == '0) begin
					state_d = ST_P_IDX;
				end
			end
			ST_P_IDX:   state_d = ST_P_RD;
			ST_P_RD:    state_d = ST_P_UPD;
			ST_P_UPD: begin
				cell_we = 1'b1;
				list_we = !cell_rd_q[MarkW] && (len_q < CountW'(CellCount));
				state_d = ST_P_NEXT;
			end
			ST_P_NEXT:  state_d = (j_q == n_q - IdxW'(1)) ? ST_E_END : ST_P_POS;
			ST_E_END:   state_d = (last_q && !closing_q) ? ST_E_SETUP : ST_RESULT;
			ST_RESULT: begin
				if (!result_valid_q || result_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Cell store: marked flag over the mark byte, cleared by sweeps.
	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		cell_rd_q <= cell_mem[cell_ra];
	end

	// Occupied list, appended at the list length.
	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[len_q[IdxW-1:0]] <= idx_q;
		end
		list_rd_q <= list_mem[item.read_index];
	end

	// Configuration and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= -32'sd324403;
			origin_y_q     <= -32'sd324403;
			cell_size_q    <= CellW'(3277);
			grid_width_q   <= DimW'(200);
			grid_height_q  <= DimW'(200);
			padding_on_q   <= 1'b0;
			padding_size_q <= CellW'(6554);
			mark_value_q   <= MarkW'(64);
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			clr_vtx_q      <= 1'b0;
			open_q         <= 1'b0;
			done_q         <= 1'b0;
			len_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ORIGIN_X:     origin_x_q     <= cfg_data;
					CFG_ORIGIN_Y:     origin_y_q     <= cfg_data;
					CFG_CELL_SIZE:    cell_size_q    <= cfg_data[CellW-1:0];
					CFG_GRID_WIDTH:   grid_width_q   <= cfg_data[DimW-1:0];
					CFG_GRID_HEIGHT:  grid_height_q  <= cfg_data[DimW-1:0];
					CFG_PADDING_ON:   padding_on_q   <= cfg_data[0];
					CFG_PADDING_SIZE: padding_size_q <= cfg_data[CellW-1:0];
					CFG_MARK_VALUE:   mark_value_q   <= cfg_data[MarkW-1:0];
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IdxW'(1);
			end
			// A first vertex starts a fresh polygon.
			if (accept && item.opcode == OP_VERTEX && !open_q) begin
				clr_vtx_q <= 1'b1;
				len_q     <= '0;
				done_q    <= 1'b0;
			end
			if (state_q == ST_VSTART) begin
				open_q <= 1'b1;
			end
			if (list_we) begin
				len_q <= len_q + CountW'(1);
			end
			// Closing edge finished.
			if (state_q == ST_E_END && state_d == ST_RESULT && last_q) begin
				open_q <= 1'b0;
				done_q <= 1'b1;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Request capture.
		if (accept) begin
			op_q      <= item.opcode;
			vx_q      <= pad_x;
			vy_q      <= pad_y;
			last_q    <= item.last_vertex;
			wasopen_q <= open_q;
			unique case (item.opcode)
				OP_READ_CELL: roor_q <= (CountW'(item.read_index) >= cells_used);
				OP_READ_LIST: roor_q <= (CountW'(item.read_index) >= len_q);
				OP_VERTEX:    roor_q <= 1'b0;
				OP_NONE:      roor_q <= 1'b0;
			endcase
		end
		if (state_q == ST_READ) begin
			rcell_q <= cell_rd_q[MarkW-1:0];
			rlist_q <= list_rd_q;
		end
		// Vertex bookkeeping and first edge endpoints.
		if (state_q == ST_VSTART) begin
			prev_x_q <= vx_q;
			prev_y_q <= vy_q;
			ex1_q    <= vx_q;
			ey1_q    <= vy_q;
			if (wasopen_q) begin
				ex0_q     <= prev_x_q;
				ey0_q     <= prev_y_q;
				closing_q <= 1'b0;
			end else begin
				first_x_q <= vx_q;
				first_y_q <= vy_q;
				ex0_q     <= vx_q;
				ey0_q     <= vy_q;
				closing_q <= 1'b1;
			end
		end
		// Closing edge back to the first vertex.
		if (state_q == ST_E_END && last_q && !closing_q) begin
			ex0_q     <= vx_q;
			ey0_q     <= vy_q;
			ex1_q     <= first_x_q;
			ey1_q     <= first_y_q;
			closing_q <= 1'b1;
		end
		// Edge setup: absolute deltas in unsigned Q16.16 and grid extents in Q14.16.
		if (state_q == ST_E_SETUP) begin
			negx_q <= dx[CoordW];
			negy_q <= dy[CoordW];
			ux_q   <= dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
			uy_q   <= dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
			cw_q   <= CwW'(csz) * CwW'(gw);
			ch_q   <= CwW'(csz) * CwW'(gh);
		end
		// Squared length through one registered squarer.
		if (state_q == ST_E_SQU || state_q == ST_E_SQV) begin
			prod_q <= mul_res;
		end
		if (state_q == ST_E_SQV) begin
			sqa_q <= prod_q;
		end
		if (state_q == ST_E_SUM) begin
			rad_q     <= (2*CoordW+2)'(sqa_q) + (2*CoordW+2)'(prod_q);
			root_q    <= '0;
			rrem_q    <= '0;
			rt_cnt_q  <= 6'd32;
			div_sel_q <= DIV_N;
		end
		// Integer square root, two radicand bits per cycle.
		if (state_q == ST_E_ROOT) begin
			rad_q    <= {rad_q[2*CoordW-1:0], 2'b00};
			rt_cnt_q <= rt_cnt_q - 6'd1;
			if (rt_sh >= rt_trial) begin
				rrem_q <= (RootW+2)'(rt_sh - rt_trial);
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rrem_q <= rt_sh[RootW+1:0];
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
		// Division results: step count, then per axis step and remainder.
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			unique case (div_sel_q)
				DIV_N: begin
					n_q       <= n_sat;
					div_sel_q <= DIV_QX;
				end
				DIV_QX: begin
					qx_q      <= div_rsp.quotient[CoordW-1:0];
					rx_q      <= div_rsp.remainder[IdxW-1:0];
					div_sel_q <= DIV_QY;
				end
				DIV_QY: begin
					qy_q    <= div_rsp.quotient[CoordW-1:0];
					ry_q    <= div_rsp.remainder[IdxW-1:0];
					accqx_q <= '0;
					accqy_q <= '0;
					accrx_q <= '0;
					accry_q <= '0;
					j_q     <= '0;
				end
				default: begin
					div_sel_q <= DIV_N;
				end
			endcase
		end
		// Point position: start plus the truncated fraction of the delta.
		if (state_q == ST_P_POS) begin
			px_q <= negx_q ? (CoordW+2)'(ex0_q) - (CoordW+2)'(accqx_q)
			               : (CoordW+2)'(ex0_q) + (CoordW+2)'(accqx_q);
			py_q <= negy_q ? (CoordW+2)'(ey0_q) - (CoordW+2)'(accqy_q)
			               : (CoordW+2)'(ey0_q) + (CoordW+2)'(accqy_q);
		end
		if (state_q == ST_P_CHK) begin
			remx_q <= offx[CwW-1:0];
			remy_q <= offy[CwW-1:0];
			k_q    <= 3'd7;
			mx_q   <= '0;
			my_q   <= '0;
		end
		// Column and row, one quotient bit per cycle.
		if (state_q == ST_P_DIV) begin
			k_q <= k_q - 3'd1;
			if (remx_q >= dsh) begin
				remx_q     <= remx_q - dsh;
				mx_q[k_q]  <= 1'b1;
			end
			if (remy_q >= dsh) begin
				remy_q     <= remy_q - dsh;
				my_q[k_q]  <= 1'b1;
			end
		end
		if (state_q == ST_P_IDX) begin
			idx_q <= IdxW'(my_q) * IdxW'(gw) + IdxW'(mx_q);
		end
		// Advance to the next step of the edge.
		if (state_q == ST_P_NEXT) begin
			j_q <= j_q + IdxW'(1);
			if (sumrx >= (IdxW+1)'(n_q)) begin
				accrx_q <= IdxW'(sumrx - (IdxW+1)'(n_q));
				accqx_q <= accqx_q + qx_q + CoordW'(1);
			end else begin
				accrx_q <= sumrx[IdxW-1:0];
				accqx_q <= accqx_q + qx_q;
			end
			if (sumry >= (IdxW+1)'(n_q)) begin
				accry_q <= IdxW'(sumry - (IdxW+1)'(n_q));
				accqy_q <= accqy_q + qy_q + CoordW'(1);
			end else begin
				accry_q <= sumry[IdxW-1:0];
				accqy_q <= accqy_q + qy_q;
			end
		end
		// Output register.
		if (res_load) begin
			result_q.cell_value        <= (op_q == OP_READ_CELL && !roor_q) ? rcell_q : '0;
			result_q.occupied_index    <= (op_q == OP_READ_LIST && !roor_q) ? rlist_q : '0;
			result_q.occupied_count    <= len_q;
			result_q.polygon_done      <= done_q;
			result_q.read_out_of_range <= roor_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/pogm_div.sv
// ----------------------------------------------------------------------------
// Polygon outline grid marker: shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pogm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pogm_pkg::div_req_t req,
	output pogm_pkg::div_rsp_t rsp
);
	import pogm_pkg::*;

	localparam int CntW = $clog2(DvdW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] quo_q;
	logic [DvsW-1:0] rem_q;
	logic [DvsW-1:0] dvs_q;
	logic [DvsW:0]   shifted;
	logic            fit;
	logic [DvsW-1:0] next_rem;

	// One trial subtraction per cycle.
	always_comb begin
		shifted  = {rem_q, quo_q[DvdW-1]};
		fit      = (shifted >= {1'b0, dvs_q});
		next_rem = fit ? DvsW'(shifted - {1'b0, dvs_q}) : shifted[DvsW-1:0];
	end

	// Sequencing of the bit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DvdW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DvdW-2:0], fit};
			rem_q <= next_rem;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> rtl/pogm_chk.sv
// ----------------------------------------------------------------------------
// Polygon outline grid marker: port checker
// Watches the top level ports and flags behavior the design must never show.
// ----------------------------------------------------------------------------
`include "polygon_outline_grid_marker_core_defines.svh"

module pogm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input pogm_pkg::result_t result
);
	import pogm_pkg::*;

	// A stalled result keeps its payload.
	`POGM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	// One request at a time: ready drops right after a request is taken.
	`POGM_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready, "request taken while busy")

	// An out of range read returns no data.
	`POGM_ASSERT_NOW(a_oor_zero, result_valid && result.read_out_of_range, result.cell_value == '0 && result.occupied_index == '0, "data on out of range read")

	// A result carries either cell data or list data, never both.
	`POGM_ASSERT_NOW(a_one_source, result_valid && result.occupied_index != '0, result.cell_value == '0, "cell and list data together")

endmodule

bind polygon_outline_grid_marker_core pogm_chk u_pogm_chk (.*);

>>> verif/tb_polygon_outline_grid_marker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polygon outline grid marker core testbench
// Drives vertex and read requests through the valid/ready request port,
// predicts every result with a behavioral model of the grid marker, and
// compares each result field by field. Directed tests cover reset contents,
// extreme coordinates with padding saturation, zero cell size, oversized and
// empty grids, single vertex polygons and the per-edge step limit; random
// polygons with interleaved reads follow under three idling patterns.
// ----------------------------------------------------------------------------
module tb_polygon_outline_grid_marker_core;
	import pogm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;

	polygon_outline_grid_marker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Grid model: configuration copy.
	int          org_x, org_y;
	int unsigned cell_len, cols_cfg, rows_cfg, pad_en, pad_len, mark_byte;

	// Grid model: stored state.
	byte unsigned cell_mem [CellCount];
	bit           cell_hit [CellCount];
	int unsigned  hit_list [CellCount];
	int unsigned  hit_count;
	int           start_x, start_y, last_x, last_y;
	bit           outline_open, outline_closed;

	result_t awaited_results[$];
	int      fail_count;
	int      send_idle_pct;
	int      recv_idle_pct;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned eff_dim(int unsigned d);
		return (d > 256) ? 256 : d;
	endfunction

	function automatic int pad_coord(int v);
		longint s;
		if (!pad_en || v == 0) return v;
		s = (v > 0) ? longint'(v) + longint'(pad_len) : longint'(v) - longint'(pad_len);
		if (s > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (s < -64'sh80000000) return 32'sh80000000;
		return int'(s);
	endfunction

	// Integer square root of a 66-bit sum of squares, two bits per step.
	function automatic longint unsigned edge_root(logic [65:0] v);
		logic [67:0] rem;
		logic [67:0] trial;
		logic [33:0] r;
		rem = '0;
		r = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | v[2*i+1 -: 2];
			trial = ({34'd0, r} << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				r = (r << 1) | 34'd1;
			end else begin
				r = r << 1;
			end
		end
		return longint'(r);
	endfunction

	function automatic void mark_cell(longint px, longint py);
		longint unsigned c, mx, my, idx;
		c = (cell_len != 0) ? cell_len : 1;
		if (px < longint'(org_x) || py < longint'(org_y)) return;
		mx = longint'(px - longint'(org_x)) / c;
		my = longint'(py - longint'(org_y)) / c;
		if (mx >= eff_dim(cols_cfg) || my >= eff_dim(rows_cfg)) return;
		idx = my * eff_dim(cols_cfg) + mx;
		if (idx >= CellCount) return;
		cell_mem[idx] = mark_byte[7:0];
		if (!cell_hit[idx]) begin
			cell_hit[idx] = 1'b1;
			if (hit_count < CellCount) begin
				hit_list[hit_count] = idx;
				hit_count++;
			end
		end
	endfunction

	function automatic void trace_edge(int x0, int y0, int x1, int y1);
		longint dx, dy, u, v, n;
		logic [65:0] sq;
		longint unsigned c;
		dx = longint'(x1) - longint'(x0);
		dy = longint'(y1) - longint'(y0);
		u = (dx < 0) ? -dx : dx;
		v = (dy < 0) ? -dy : dy;
		sq = 66'(u) * 66'(u) + 66'(v) * 66'(v);
		c = (cell_len != 0) ? cell_len : 1;
		n = longint'((10 * edge_root(sq)) / (9 * c));
		if (n > StepMax) n = StepMax;
		for (longint j = 0; j < n; j++)
			mark_cell(longint'(x0) + (j * dx) / n, longint'(y0) + (j * dy) / n);
	endfunction

	// Applies one request to the grid model and returns the result it gives.
	function automatic result_t grid_response(item_t it);
		result_t r;
		int x, y;
		r = '0;
		case (it.opcode)
			OP_VERTEX: begin
				x = pad_coord(it.vertex_x);
				y = pad_coord(it.vertex_y);
				if (!outline_open) begin
					for (int i = 0; i < CellCount; i++) begin
						cell_mem[i] = 0;
						cell_hit[i] = 0;
					end
					hit_count = 0;
					outline_closed = 0;
					outline_open = 1;
					start_x = x;
					start_y = y;
				end else begin
					trace_edge(last_x, last_y, x, y);
				end
				last_x = x;
				last_y = y;
				if (it.last_vertex) begin
					trace_edge(x, y, start_x, start_y);
					outline_open = 0;
					outline_closed = 1;
				end
			end
			OP_READ_CELL: begin
				if (it.read_index >= eff_dim(cols_cfg) * eff_dim(rows_cfg))
					r.read_out_of_range = 1'b1;
				else
					r.cell_value = cell_mem[it.read_index];
			end
			OP_READ_LIST: begin
				if (it.read_index >= hit_count)
					r.read_out_of_range = 1'b1;
				else
					r.occupied_index = hit_list[it.read_index][15:0];
			end
			default: ;
		endcase
		r.occupied_count = hit_count[CountW-1:0];
		r.polygon_done = outline_closed;
		return r;
	endfunction

	// Waits until the block has drained and can take a request.
	task automatic wait_idle();
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_ORIGIN_X:     org_x = data;
			CFG_ORIGIN_Y:     org_y = data;
			CFG_CELL_SIZE:    cell_len = data[20:0];
			CFG_GRID_WIDTH:   cols_cfg = data[8:0];
			CFG_GRID_HEIGHT:  rows_cfg = data[8:0];
			CFG_PADDING_ON:   pad_en = data[0];
			CFG_PADDING_SIZE: pad_len = data[20:0];
			CFG_MARK_VALUE:   mark_byte = data[7:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends one request; valid stays high afterwards until the next call decides.
	task automatic send_item(item_t it);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		awaited_results.insert(awaited_results.size(), grid_response(it));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	function automatic item_t vertex_req(int x, int y, bit last);
		item_t it;
		it = '0;
		it.opcode = OP_VERTEX;
		it.vertex_x = x;
		it.vertex_y = y;
		it.last_vertex = last;
		it.read_index = $urandom();
		return it;
	endfunction

	function automatic item_t read_req(opcode_t op, int unsigned idx);
		item_t it;
		it.opcode = op;
		it.vertex_x = $urandom();
		it.vertex_y = $urandom();
		it.last_vertex = $urandom_range(0, 1);
		it.read_index = idx[15:0];
		return it;
	endfunction

	// Result checker: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (result.cell_value !== want.cell_value) begin
					$error("cell_value: expected %0d, got %0d", want.cell_value,
						result.cell_value);
					fail_count++;
				end
				if (result.occupied_index !== want.occupied_index) begin
					$error("occupied_index: expected %0d, got %0d", want.occupied_index,
						result.occupied_index);
					fail_count++;
				end
				if (result.occupied_count !== want.occupied_count) begin
					$error("occupied_count: expected %0d, got %0d", want.occupied_count,
						result.occupied_count);
					fail_count++;
				end
				if (result.polygon_done !== want.polygon_done) begin
					$error("polygon_done: expected %0d, got %0d", want.polygon_done,
						result.polygon_done);
					fail_count++;
				end
				if (result.read_out_of_range !== want.read_out_of_range) begin
					$error("read_out_of_range: expected %0d, got %0d",
						want.read_out_of_range, result.read_out_of_range);
					fail_count++;
				end
			end
		end
	end

	// Receiver stalls.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Reset contents and reset configuration, read back through both read ops.
	task automatic test_reset_state();
		send_item(read_req(OP_READ_CELL, 0));
		send_item(read_req(OP_READ_CELL, 39999));
		send_item(read_req(OP_READ_CELL, 40000));
		send_item(read_req(OP_READ_LIST, 0));
		send_item(read_req(OP_NONE, 65535));
		stop_sending();
	endtask

	// Extreme coordinates, padding that saturates, a large cell and the largest grid.
	task automatic test_extremes();
		wait_idle();
		write_reg(CFG_ORIGIN_X, 32'h8000_0000);
		write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
		write_reg(CFG_CELL_SIZE, 32'd1048576);
		write_reg(CFG_GRID_WIDTH, 32'd256);
		write_reg(CFG_GRID_HEIGHT, 32'd256);
		write_reg(CFG_PADDING_ON, 32'd1);
		write_reg(CFG_PADDING_SIZE, 32'd1048576);
		write_reg(CFG_MARK_VALUE, 32'd255);
		send_item(vertex_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
		send_item(vertex_req(32'sh8000_0000, 32'sh8000_0000, 1'b0));
		send_item(vertex_req(0, 0, 1'b0));
		send_item(vertex_req($urandom(), $urandom(), 1'b0));
		send_item(vertex_req(~$urandom(), ~$urandom(), 1'b1));
		send_item(read_req(OP_READ_LIST, 0));
		send_item(read_req(OP_READ_CELL, 0));
		send_item(read_req(OP_READ_CELL, 65535));
		send_item(read_req(OP_READ_LIST, 65535));
		stop_sending();
	endtask

	// Zero cell size, oversized and empty grids, single vertex, step limit.
	task automatic test_special_cases();
		wait_idle();
		write_reg(CFG_PADDING_ON, 32'd0);
		write_reg(CFG_ORIGIN_X, 32'd0);
		write_reg(CFG_ORIGIN_Y, 32'd0);
		write_reg(CFG_CELL_SIZE, 32'd0);
		write_reg(CFG_GRID_WIDTH, 32'd511);
		write_reg(CFG_GRID_HEIGHT, 32'd0);
		write_reg(CFG_MARK_VALUE, 32'd0);
		// Empty grid: nothing lands, a cell read is out of range.
		send_item(vertex_req(10, 10, 1'b0));
		send_item(vertex_req(60, 40, 1'b1));
		send_item(read_req(OP_READ_CELL, 0));
		stop_sending();
		wait_idle();
		write_reg(CFG_GRID_HEIGHT, 32'd3);
		send_item(vertex_req(5, 0, 1'b0));
		send_item(vertex_req(90, 2, 1'b0));
		send_item(vertex_req(300, 1, 1'b1));
		send_item(read_req(OP_READ_LIST, 1));
		send_item(read_req(OP_READ_CELL, 767));
		// Single vertex polygon clears the store and closes at once.
		send_item(vertex_req(7, 1, 1'b1));
		stop_sending();
		// Edge long enough to hit the step limit, all points left of the origin.
		wait_idle();
		write_reg(CFG_CELL_SIZE, 32'd1);
		write_reg(CFG_ORIGIN_X, 32'd1_000_000);
		send_item(vertex_req(0, 0, 1'b0));
		send_item(vertex_req(70000, 0, 1'b1));
		send_item(read_req(OP_READ_LIST, 0));
		stop_sending();
	endtask

	// Random polygons with reads mixed in, under a fresh configuration.
	task automatic test_random_polygons(int n_items);
		int sent, nv, span, w, h;
		longint c;
		sent = 0;
		while (sent < n_items) begin
			wait_idle();
			write_reg(CFG_ORIGIN_X, $urandom_range(0, 1 << 25) - (1 << 24));
			write_reg(CFG_ORIGIN_Y, $urandom_range(0, 1 << 25) - (1 << 24));
			write_reg(CFG_CELL_SIZE, $urandom_range(500, 20000));
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
			write_reg(CFG_GRID_WIDTH, w);
			write_reg(CFG_GRID_HEIGHT, h);
			write_reg(CFG_PADDING_ON, $urandom_range(0, 1));
			write_reg(CFG_PADDING_SIZE, $urandom_range(0, 4 * cell_len));
			write_reg(CFG_MARK_VALUE, $urandom_range(0, 255));
			c = cell_len;
			span = int'(c * ((eff_dim(cols_cfg) > eff_dim(rows_cfg)) ?
				eff_dim(cols_cfg) : eff_dim(rows_cfg)) / 3) + 1;
			nv = $urandom_range(1, 6);
			for (int v = 0; v < nv; v++) begin
				send_item(vertex_req(org_x + $urandom_range(0, span) - span / 8,
					org_y + $urandom_range(0, span) - span / 8, v == nv - 1));
				sent++;
				if ($urandom_range(0, 3) == 0) begin
					send_item(read_req(OP_READ_LIST, $urandom_range(0, hit_count)));
					sent++;
				end
			end
			for (int k = 0; k < 40; k++) begin
				case ($urandom_range(0, 9))
					0: send_item(read_req(OP_READ_CELL, $urandom()));
					1: send_item(read_req(OP_READ_LIST, $urandom()));
					2: send_item(read_req(OP_NONE, $urandom()));
					3, 4, 5: send_item(read_req(OP_READ_LIST, $urandom_range(0, hit_count)));
					default: send_item(read_req(OP_READ_CELL, (hit_count != 0) ?
						hit_list[$urandom_range(0, hit_count - 1)] :
						$urandom_range(0, 65535)));
				endcase
				sent++;
			end
			stop_sending();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ORIGIN_X;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		fail_count = 0;
		send_idle_pct = 22;
		recv_idle_pct = 80;
		org_x = -324403;
		org_y = -324403;
		cell_len = 3277;
		cols_cfg = 200;
		rows_cfg = 200;
		pad_en = 0;
		pad_len = 6554;
		mark_byte = 64;
		hit_count = 0;
		start_x = 0;
		start_y = 0;
		last_x = 0;
		last_y = 0;
		outline_open = 0;
		outline_closed = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_idle();

		test_reset_state();
		test_extremes();
		test_special_cases();
		test_random_polygons(250);
		send_idle_pct = 80;
		recv_idle_pct = 22;
		test_random_polygons(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_polygons(250);

		stop_sending();
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pogm_pkg.sv
rtl/pogm_div.sv
rtl/polygon_outline_grid_marker_core.sv
rtl/pogm_chk.sv
verif/tb_polygon_outline_grid_marker_core.sv
